>>> rtl/ncr_pkg.sv
package ncr_pkg;

   // Protocol numbers that carry a rewritable layer-4 checksum
   localparam logic [7:0] PROTO_TCP     = 8'd6;
   localparam logic [7:0] PROTO_UDP     = 8'd17;
   localparam logic [7:0] PROTO_UDPLITE = 8'd136;
   localparam logic [7:0] PROTO_DCCP    = 8'd33;

   // Checksum byte offsets inside the layer-4 header
   localparam logic [15:0] TCP_CSUM_OFF  = 16'd16;
   localparam logic [15:0] DCCP_CSUM_OFF = 16'd6;
   localparam logic [15:0] UDP_CSUM_OFF  = 16'd6;

   localparam logic [15:0] CSUM_ALL_ONES = 16'hFFFF;
   localparam logic [15:0] CSUM_NONE     = 16'h0000;

   typedef struct packed {
      logic [3:0]  header_words;
      logic [15:0] packet_length;
      logic [7:0]  protocol;
      logic [15:0] frag_field;
      logic [15:0] ip_checksum;
      logic [15:0] l4_checksum;
      logic [31:0] old_source;
      logic [31:0] old_dest;
      logic [31:0] new_source;
      logic [31:0] new_dest;
   } req_type;

   typedef struct packed {
      logic [15:0] new_ip_checksum;
      logic [15:0] new_l4_checksum;
      logic        l4_write;
      logic [4:0]  l4_offset;
   } rsp_type;

   // Old and new addresses shared by both checksum lanes
   typedef struct packed {
      logic [31:0] old_source;
      logic [31:0] old_dest;
      logic [31:0] new_source;
      logic [31:0] new_dest;
   } addr_type;

   // Layer-4 rewrite decision carried down the pipeline
   typedef struct packed {
      logic       write;
      logic       remap;
      logic [4:0] offset;
   } l4ctl_type;

   // Sum of the two halfwords of an address
   function automatic logic [16:0] halves_of(input logic [31:0] x);
      return {1'b0, x[15:0]} + {1'b0, x[31:16]};
   endfunction

endpackage

>>> rtl/ncr_classify.sv
module ncr_classify (
   input  logic                 clock,
   input  logic [3:0]           header_words,
   input  logic [15:0]          packet_length,
   input  logic [7:0]           protocol,
   input  logic [15:0]          frag_field,
   input  logic [15:0]          l4_checksum,
   output ncr_pkg::l4ctl_type   ctl_ff
);
   import ncr_pkg::*;

   logic [15:0] frag_bytes;
   logic        header_fits;
   logic        is_stream;
   logic        is_dgram;
   logic [15:0] csum_off;
   logic [15:0] rel_off;
   l4ctl_type   ctl_in;

   // Locate this fragment and check the header fits in the packet
   assign frag_bytes  = {frag_field[12:0], 3'b000};
   assign header_fits = ({10'd0, header_words, 2'b00} <= packet_length);

   // Decide whether and where the layer-4 checksum gets rewritten
   always_comb begin
      is_stream = (protocol == PROTO_TCP) || (protocol == PROTO_DCCP);
      is_dgram  = (protocol == PROTO_UDP) || (protocol == PROTO_UDPLITE);
      if (protocol == PROTO_TCP) begin
         csum_off = TCP_CSUM_OFF;
      end else if (protocol == PROTO_DCCP) begin
         csum_off = DCCP_CSUM_OFF;
      end else begin
         csum_off = UDP_CSUM_OFF;
      end
      rel_off = csum_off - frag_bytes;
      ctl_in.write = header_fits && (frag_bytes <= csum_off) &&
                     (is_stream || (is_dgram && (l4_checksum != CSUM_NONE)));
      ctl_in.remap  = is_stream;
      ctl_in.offset = ctl_in.write ? rel_off[4:0] : 5'd0;
   end

   always_ff @(posedge clock) begin
      ctl_ff <= ctl_in;
   end

endmodule

>>> rtl/ncr_adjust.sv
module ncr_adjust (
   input  logic              clock,
   input  logic [15:0]       word,
   input  ncr_pkg::addr_type addr,
   output logic [15:0]       result_ff
);
   import ncr_pkg::*;

   logic [17:0] old_pair_ff, old_pair_in;
   logic [17:0] new_pair_ff, new_pair_in;
   logic [15:0] word_ff;
   logic [19:0] sum_ff, sum_in;
   logic [16:0] fold_one;
   logic [16:0] fold_two;
   logic [15:0] result_in;

   // Stage one: add halfwords of old addresses and of complemented new ones
   assign old_pair_in = {1'b0, halves_of(addr.old_source)} +
                        {1'b0, halves_of(addr.old_dest)};
   assign new_pair_in = {1'b0, halves_of(~addr.new_source)} +
                        {1'b0, halves_of(~addr.new_dest)};

   // Stage two: add both pairs to the checksum word
   assign sum_in = {4'd0, word_ff} + {2'd0, old_pair_ff} + {2'd0, new_pair_ff};

   // Stage three: fold the carries back twice
   assign fold_one  = {1'b0, sum_ff[15:0]} + {13'd0, sum_ff[19:16]};
   assign fold_two  = fold_one + {16'd0, fold_one[16]};
   assign result_in = fold_two[15:0];

   always_ff @(posedge clock) begin
      old_pair_ff <= old_pair_in;
      new_pair_ff <= new_pair_in;
      word_ff     <= word;
      sum_ff      <= sum_in;
      result_ff   <= result_in;
   end

endmodule

>>> rtl/ipv4_nat_checksum_rewrite.sv
// Channel   Ports                        Handshake
// -------   --------------------------   ------------------------------------
// request   start, busy, req_item        taken when start high and busy low
// response  rsp_valid, rsp_item          one cycle per result, no back-pressure
//
// One header enters every cycle.
// Latency is set by the three register stages of the checksum adder lanes:
// pair sums, full sum, then the double carry fold.
// busy stays low: the response side never stalls, so nothing waits.
// Synchronous reset clears the valid bits; data registers are not reset.
module ipv4_nat_checksum_rewrite (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ncr_pkg::req_type req_item,
   output logic             rsp_valid,
   output ncr_pkg::rsp_type rsp_item
);
   import ncr_pkg::*;

   logic [2:0] valid_ff, valid_in;
   addr_type   addr;
   l4ctl_type  ctl_s1;
   l4ctl_type  ctl_s2_ff;
   l4ctl_type  ctl_s3_ff;
   logic [15:0] ip_sum;
   logic [15:0] l4_sum;
   logic [15:0] l4_final;

   assign busy = 1'b0;

   assign addr.old_source = req_item.old_source;
   assign addr.old_dest   = req_item.old_dest;
   assign addr.new_source = req_item.new_source;
   assign addr.new_dest   = req_item.new_dest;

   // Advance valid bits with the data
   assign valid_in = {valid_ff[1:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 3'b000;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Layer-4 decision: registered in stage one, then held alongside the sums
   ncr_classify u_classify (
      .clock         (clock),
      .header_words  (req_item.header_words),
      .packet_length (req_item.packet_length),
      .protocol      (req_item.protocol),
      .frag_field    (req_item.frag_field),
      .l4_checksum   (req_item.l4_checksum),
      .ctl_ff        (ctl_s1)
   );

   always_ff @(posedge clock) begin
      ctl_s2_ff <= ctl_s1;
      ctl_s3_ff <= ctl_s2_ff;
   end

   ncr_adjust u_ip_adjust (
      .clock     (clock),
      .word      (req_item.ip_checksum),
      .addr      (addr),
      .result_ff (ip_sum)
   );

   ncr_adjust u_l4_adjust (
      .clock     (clock),
      .word      (req_item.l4_checksum),
      .addr      (addr),
      .result_ff (l4_sum)
   );

   // Map all-ones to zero for TCP and DCCP; drop the value when not written
   always_comb begin
      if (!ctl_s3_ff.write) begin
         l4_final = CSUM_NONE;
      end else if (ctl_s3_ff.remap && (l4_sum == CSUM_ALL_ONES)) begin
         l4_final = CSUM_NONE;
      end else begin
         l4_final = l4_sum;
      end
   end

   assign rsp_valid                = valid_ff[2];
   assign rsp_item.new_ip_checksum = ip_sum;
   assign rsp_item.new_l4_checksum = l4_final;
   assign rsp_item.l4_write        = ctl_s3_ff.write;
   assign rsp_item.l4_offset       = ctl_s3_ff.offset;

   // Every result comes from a transaction taken at the head of the valid pipeline
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 3))
      else $error("result without a transaction three cycles back");

   // No rewrite means zero value and zero offset
   a_no_write_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.l4_write) |->
      (rsp_item.new_l4_checksum == 16'd0 && rsp_item.l4_offset == 5'd0))
      else $error("layer-4 fields set without a rewrite");

   // Offset never passes the TCP checksum position
   a_offset_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.l4_write) |-> (rsp_item.l4_offset <= 5'd16))
      else $error("layer-4 offset out of range");

endmodule

>>> tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ncr_pkg::*;

   localparam int          WATCHDOG_LIMIT   = 2000;
   localparam int          SETTLE_CYCLES    = 8;
   localparam int          RANDOM_HEADERS   = 1800;
   localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1FFF;

   // Expected rewrites for accepted headers, oldest first
   class rewrite_tracker;
      rsp_type pending_rewrites[$];
      int      errors = 0;

      // Add old address halfwords and complemented new ones, fold carries twice
      static function logic [15:0] adjust_word(logic [15:0] word, logic [31:0] os,
                                               logic [31:0] od, logic [31:0] ns,
                                               logic [31:0] nd);
         logic [31:0] acc;
         logic [31:0] ns_inv;
         logic [31:0] nd_inv;
         ns_inv = ~ns;
         nd_inv = ~nd;
         acc = 32'(word) + 32'(os[15:0]) + 32'(os[31:16]) + 32'(od[15:0])
             + 32'(od[31:16]) + 32'(ns_inv[15:0]) + 32'(ns_inv[31:16])
             + 32'(nd_inv[15:0]) + 32'(nd_inv[31:16]);
         acc = 32'(acc[15:0]) + 32'(acc[31:16]);
         acc = 32'(acc[15:0]) + 32'(acc[31:16]);
         return acc[15:0];
      endfunction

      function rsp_type compute_rewrite(req_type h);
         rsp_type r;
         int      frag_bytes;
         int      csum_off;
         r = '0;
         r.new_ip_checksum = adjust_word(h.ip_checksum, h.old_source, h.old_dest,
                                         h.new_source, h.new_dest);
         frag_bytes = int'(h.frag_field & FRAG_OFFSET_MASK) * 8;
         // Layer-4 word only when the header fits in the packet held
         if (int'(h.header_words) * 4 <= int'(h.packet_length)) begin
            if (h.protocol == PROTO_TCP || h.protocol == PROTO_DCCP) begin
               csum_off = (h.protocol == PROTO_TCP) ? int'(TCP_CSUM_OFF)
                                                    : int'(DCCP_CSUM_OFF);
               if (frag_bytes <= csum_off) begin
                  r.new_l4_checksum = adjust_word(h.l4_checksum, h.old_source,
                                                  h.old_dest, h.new_source, h.new_dest);
                  if (r.new_l4_checksum == CSUM_ALL_ONES)
                     r.new_l4_checksum = CSUM_NONE;
                  r.l4_offset = 5'(csum_off - frag_bytes);
                  r.l4_write  = 1'b1;
               end
            end else if (h.protocol == PROTO_UDP || h.protocol == PROTO_UDPLITE) begin
               // A zero UDP checksum means none present: leave it alone
               if (frag_bytes <= int'(UDP_CSUM_OFF) && h.l4_checksum != CSUM_NONE) begin
                  r.new_l4_checksum = adjust_word(h.l4_checksum, h.old_source,
                                                  h.old_dest, h.new_source, h.new_dest);
                  r.l4_offset = 5'(int'(UDP_CSUM_OFF) - frag_bytes);
                  r.l4_write  = 1'b1;
               end
            end
         end
         return r;
      endfunction

      function void note_header(req_type h);
         pending_rewrites.push_back(compute_rewrite(h));
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t rewrite mismatch on %s: expected %h, actual %h",
                     $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_rewrite(rsp_type got);
         rsp_type want;
         if (pending_rewrites.size() == 0) begin
            $display("%0t unexpected rewrite: expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending_rewrites.pop_front();
         compare_field("new_ip_checksum", want.new_ip_checksum, got.new_ip_checksum);
         compare_field("new_l4_checksum", want.new_l4_checksum, got.new_l4_checksum);
         compare_field("l4_write", want.l4_write, got.l4_write);
         compare_field("l4_offset", want.l4_offset, got.l4_offset);
      endfunction

      function int pending();
         return pending_rewrites.size();
      endfunction
   endclass

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   rewrite_tracker tracker = new;
   int             quiet_cycles = 0;

   ipv4_nat_checksum_rewrite u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #10 clock = ~clock;

   // Record accepted headers, check rewrites, watch for a stalled block
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            tracker.note_header(req_item);
         if (rsp_valid)
            tracker.check_rewrite(rsp_item);
         if ((start && !busy) || rsp_valid)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic req_type make_header(logic [3:0] hw, logic [15:0] plen,
                                           logic [7:0] proto, logic [15:0] frag,
                                           logic [15:0] ipck, logic [15:0] l4ck,
                                           logic [31:0] os, logic [31:0] od,
                                           logic [31:0] ns, logic [31:0] nd);
      req_type h;
      h.header_words  = hw;
      h.packet_length = plen;
      h.protocol      = proto;
      h.frag_field    = frag;
      h.ip_checksum   = ipck;
      h.l4_checksum   = l4ck;
      h.old_source    = os;
      h.old_dest      = od;
      h.new_source    = ns;
      h.new_dest      = nd;
      return h;
   endfunction

   // Mostly well-formed NAT headers, some noise in every field
   function automatic req_type random_header();
      req_type h;
      int      pick;
      h.header_words = 4'($urandom);
      h.packet_length = ($urandom_range(99) < 90) ? 16'($urandom_range(65535, 60))
                                                  : 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 20)      h.protocol = PROTO_TCP;
      else if (pick < 40) h.protocol = PROTO_UDP;
      else if (pick < 60) h.protocol = PROTO_UDPLITE;
      else if (pick < 80) h.protocol = PROTO_DCCP;
      else                h.protocol = 8'($urandom);
      h.frag_field = ($urandom_range(99) < 75) ? {3'($urandom), 13'($urandom_range(3))}
                                               : 16'($urandom);
      h.ip_checksum = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 10)      h.l4_checksum = CSUM_NONE;
      else if (pick < 15) h.l4_checksum = CSUM_ALL_ONES;
      else                h.l4_checksum = 16'($urandom);
      h.old_source = $urandom;
      h.old_dest   = $urandom;
      if ($urandom_range(99) < 10) begin
         h.new_source = h.old_source;
         h.new_dest   = h.old_dest;
      end else begin
         h.new_source = $urandom;
         h.new_dest   = $urandom;
      end
      return h;
   endfunction

   // Offer one header, idling first at the given rate, hold until taken
   task automatic send_header(req_type h, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= h;
      do
         @(posedge clock);
      while (busy);
   endtask

   // Hold off the sender until every outstanding rewrite has come back
   task automatic wait_for_rewrites();
      start <= 1'b0;
      do
         @(posedge clock);
      while (tracker.pending() != 0);
   endtask

   initial begin
      int          idle_rates[4];
      logic [31:0] addr_a;
      logic [31:0] addr_b;
      idle_rates = '{0, 80, 0, 36};
      addr_a = $urandom;
      addr_b = $urandom;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, each protocol and every special case
      send_header(make_header(4'd5, 16'd60, PROTO_TCP, 16'h0000, 16'($urandom),
                              16'($urandom), $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'd0, 16'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000,
                              32'd0, 32'd0, 32'd0, 32'd0), 0);
      send_header(make_header(4'hF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              '1, '1, '1, '1), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_TCP, 16'h0000, 16'h1234,
                              CSUM_ALL_ONES, addr_a, addr_b, addr_a, addr_b), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_TCP, 16'h0002, 16'($urandom),
                              16'($urandom), $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_TCP, 16'h0003, 16'($urandom),
                              16'($urandom), $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_TCP, 16'h1FFF, 16'($urandom),
                              16'($urandom), $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_DCCP, 16'h0000, 16'($urandom),
                              16'($urandom), $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_DCCP, 16'h0001, 16'($urandom),
                              16'($urandom), $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_DCCP, 16'h0000, 16'($urandom),
                              CSUM_NONE, addr_a, addr_b, addr_a, addr_b), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_UDP, 16'h0000, 16'($urandom),
                              CSUM_NONE, $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_UDP, 16'h0000, 16'($urandom),
                              16'hBEEF, $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_UDP, 16'hE000, 16'($urandom),
                              16'h0101, $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_UDP, 16'h0001, 16'($urandom),
                              16'h0101, $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_UDP, 16'h0000, CSUM_NONE,
                              CSUM_ALL_ONES, addr_a, addr_b, addr_a, addr_b), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_UDPLITE, 16'h4000, 16'($urandom),
                              16'h7FFF, $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'd5, 16'd40, PROTO_UDPLITE, 16'h0000, 16'($urandom),
                              CSUM_NONE, $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'hF, 16'd59, PROTO_TCP, 16'h0000, 16'($urandom),
                              16'($urandom), $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'hF, 16'd60, PROTO_UDP, 16'h0000, 16'($urandom),
                              16'h8000, $urandom, $urandom, $urandom, $urandom), 0);
      send_header(make_header(4'd5, 16'd40, 8'd1, 16'h0000, CSUM_ALL_ONES,
                              16'($urandom), addr_a, addr_b, addr_a, addr_b), 0);
      wait_for_rewrites();

      // Random headers across the idling phases, draining between phases
      foreach (idle_rates[p]) begin
         repeat (RANDOM_HEADERS / 4)
            send_header(random_header(), idle_rates[p]);
         wait_for_rewrites();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
rtl/ncr_pkg.sv
rtl/ncr_classify.sv
rtl/ncr_adjust.sv
rtl/ipv4_nat_checksum_rewrite.sv
tb/testbench.sv
